/* rtl/core/htpp_pkg.sv */
// ----------------------------------------------------------------------------
// htpp_pkg: shared types and constants for the permuted-probe hash table
// Table depth, field widths, command and status codes, store request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package htpp_pkg;

  localparam int DEPTH   = 64;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int COUNT_W = SLOT_W + 1;
  localparam int KEY_W   = 32;
  localparam int OFF_W   = 6;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CFG_W   = 7;
  localparam int STEP_W  = $clog2(KEY_W) + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [SLOT_W-1:0] kv_rd_addr;
    logic              kv_wr;
    logic [SLOT_W-1:0] kv_wr_addr;
    logic [KEY_W-1:0]  wr_key;
    logic [KEY_W-1:0]  wr_value;
    logic              off_wr;
    logic [SLOT_W-1:0] off_wr_addr;
    logic [OFF_W-1:0]  off_wr_data;
    logic [SLOT_W-1:0] off_rd_addr;
    logic              clear;
  } store_req_t;

endpackage

`default_nettype wire

/* rtl/core/htpp_mod_unit.sv */
// ----------------------------------------------------------------------------
// htpp_mod_unit: bit-serial remainder unit
// Restoring remainder of an unsigned dividend by the active size, one bit per
// cycle, for a programmable number of leading dividend bits.
// ----------------------------------------------------------------------------
`default_nettype none

module htpp_mod_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [htpp_pkg::KEY_W-1:0]   dividend,
  input  wire logic [htpp_pkg::STEP_W-1:0]  steps,
  input  wire logic [htpp_pkg::COUNT_W-1:0] divisor,
  output logic                              done,
  output logic [htpp_pkg::COUNT_W-1:0]      rem
);
  import htpp_pkg::*;

  logic                 busy;
  logic [STEP_W-1:0]    cnt;
  logic [KEY_W-1:0]     shreg;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     trial_red;

  always_comb begin
    trial = {rem, shreg[KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial_red = trial - {1'b0, divisor};
    end else begin
      trial_red = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= trial_red[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/htpp_store.sv */
// ----------------------------------------------------------------------------
// htpp_store: slot and probe offset storage
// Key and value memories with registered read, occupancy flags cleared at
// once, and the probe offset memory.
// ----------------------------------------------------------------------------
`default_nettype none

module htpp_store (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire htpp_pkg::store_req_t         req,
  output logic [htpp_pkg::KEY_W-1:0]        rd_key,
  output logic [htpp_pkg::KEY_W-1:0]        rd_value,
  output logic [htpp_pkg::OFF_W-1:0]        off_data,
  output logic [htpp_pkg::DEPTH-1:0]        occ
);
  import htpp_pkg::*;

  logic [KEY_W-1:0] key_mem   [DEPTH];
  logic [KEY_W-1:0] value_mem [DEPTH];
  logic [OFF_W-1:0] off_mem   [DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.kv_wr) begin
      key_mem[req.kv_wr_addr]   <= req.wr_key;
      value_mem[req.kv_wr_addr] <= req.wr_value;
    end
    rd_key   <= key_mem[req.kv_rd_addr];
    rd_value <= value_mem[req.kv_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (req.off_wr) begin
      off_mem[req.off_wr_addr] <= req.off_wr_data;
    end
    off_data <= off_mem[req.off_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      occ <= '0;
    end else if (req.kv_wr) begin
      occ[req.kv_wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hash_table_permuted_probe.sv */
// ----------------------------------------------------------------------------
// hash_table_permuted_probe: open-addressing key/value table
// Find scans the active slots; add also scans, then takes the home slot and each
//   probe slot from the remainder unit; load, clear and full refusal skip both.
// Throughput: one transaction at a time, set by the slot scan and the
//   bit-serial remainder unit shared by home and probe slots.
// Reset: flags, entry count and sequencer clear; size goes to 64.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_permuted_probe (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [htpp_pkg::CMD_W-1:0]        cmd,
  input  wire logic [htpp_pkg::SLOT_W-1:0]       offset_index,
  input  wire logic [htpp_pkg::OFF_W-1:0]        probe_offset,
  input  wire logic signed [htpp_pkg::KEY_W-1:0] key,
  input  wire logic signed [htpp_pkg::KEY_W-1:0] entry_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [htpp_pkg::STAT_W-1:0]            status,
  output logic [htpp_pkg::SLOT_W-1:0]            slot,
  output logic signed [htpp_pkg::KEY_W-1:0]      found_value,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [htpp_pkg::CFG_W-1:0]        table_size
);
  import htpp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EXEC   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_MOD    = 8'b0000_1000,
    S_CHK    = 8'b0001_0000,
    S_PRD    = 8'b0010_0000,
    S_PMOD   = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [CFG_W-1:0]    size_cfg;
  logic [COUNT_W-1:0]  m_act;
  logic [COUNT_W-1:0]  count;
  logic [CMD_W-1:0]    op;
  logic [SLOT_W-1:0]   idx;
  logic [OFF_W-1:0]    off;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    val_r;
  logic [COUNT_W-1:0]  scan_addr;
  logic                cmp_valid;
  logic [SLOT_W-1:0]   cmp_idx;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   pos;
  logic [COUNT_W-1:0]  probes;
  logic [STAT_W-1:0]   res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_W-1:0]    res_value;

  store_req_t          req;
  logic [KEY_W-1:0]    rd_key;
  logic [KEY_W-1:0]    rd_value;
  logic [OFF_W-1:0]    off_data;
  logic [DEPTH-1:0]    occ;

  logic                mod_start;
  logic [KEY_W-1:0]    mod_dividend;
  logic [STEP_W-1:0]   mod_steps;
  logic                mod_done;
  logic [COUNT_W-1:0]  mod_rem;

  logic                hit;
  logic                scan_last;
  logic                scan_more;
  logic [KEY_W-1:0]    key_abs;
  logic [COUNT_W-1:0]  home_calc;
  logic                pos_free;
  logic [COUNT_W-1:0]  probes_inc;
  logic                probes_out;
  logic                out_free;
  logic [COUNT_W-1:0]  probe_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (size_cfg == '0) begin
      m_act = COUNT_W'(1);
    end else if (int'(size_cfg) > DEPTH) begin
      m_act = COUNT_W'(DEPTH);
    end else begin
      m_act = COUNT_W'(size_cfg);
    end
  end

  assign hit        = cmp_valid && occ[cmp_idx] && (rd_key == key_r);
  assign scan_last  = cmp_valid && ({1'b0, cmp_idx} == (m_act - COUNT_W'(1)));
  assign scan_more  = (scan_addr < m_act);
  assign key_abs    = key_r[KEY_W-1] ? (~key_r + KEY_W'(1)) : key_r;
  assign home_calc  = (key_r[KEY_W-1] && (mod_rem != '0)) ? (m_act - mod_rem) : mod_rem;
  assign pos_free   = !occ[pos];
  assign probes_inc = probes + COUNT_W'(1);
  assign probes_out = (probes_inc >= m_act);
  assign probe_sum  = COUNT_W'(home) + COUNT_W'(off_data);

  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = key_abs;
    mod_steps    = STEP_W'(KEY_W);
    if (state == S_SCAN && !hit && scan_last && op == CMD_ADD) begin
      mod_start = 1'b1;
    end else if (state == S_PRD) begin
      mod_start    = 1'b1;
      mod_dividend = {probe_sum, {(KEY_W-COUNT_W){1'b0}}};
      mod_steps    = STEP_W'(COUNT_W);
    end
  end

  always_comb begin
    req             = '0;
    req.kv_rd_addr  = scan_addr[SLOT_W-1:0];
    req.kv_wr       = (state == S_CHK) && pos_free;
    req.kv_wr_addr  = pos;
    req.wr_key      = key_r;
    req.wr_value    = val_r;
    req.off_wr      = (state == S_EXEC) && (op == CMD_LOAD) && (int'(idx) < DEPTH - 1);
    req.off_wr_addr = idx;
    req.off_wr_data = off;
    req.off_rd_addr = probes[SLOT_W-1:0];
    req.clear       = (state == S_EXEC) && (op == CMD_CLEAR);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == CMD_FIND || (op == CMD_ADD && count < m_act)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          state_next = S_RESULT;
        end else if (scan_last) begin
          state_next = (op == CMD_ADD) ? S_MOD : S_RESULT;
        end
      end
      S_MOD: begin
        if (mod_done) state_next = S_CHK;
      end
      S_CHK: begin
        if (pos_free || probes_out) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_PRD;
        end
      end
      S_PRD: state_next = S_PMOD;
      S_PMOD: begin
        if (mod_done) state_next = S_CHK;
      end
      S_RESULT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      size_cfg  <= SIZE_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) size_cfg <= table_size;
      if (state == S_EXEC && op == CMD_CLEAR) count <= '0;
      if (state == S_CHK && pos_free) count <= count + COUNT_W'(1);
      if (state == S_SCAN) begin
        cmp_valid <= scan_more;
      end else begin
        cmp_valid <= 1'b0;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op        <= cmd;
        idx       <= offset_index;
        off       <= probe_offset;
        key_r     <= key;
        val_r     <= entry_value;
        scan_addr <= '0;
      end
      S_EXEC: begin
        res_status <= (op == CMD_ADD) ? ST_FULL : ST_DONE;
        res_slot   <= '0;
        res_value  <= '0;
      end
      S_SCAN: begin
        if (scan_more) scan_addr <= scan_addr + COUNT_W'(1);
        cmp_idx <= scan_addr[SLOT_W-1:0];
        priority if (hit) begin
          res_status <= (op == CMD_FIND) ? ST_FOUND : ST_DUP;
          res_slot   <= cmp_idx;
          res_value  <= (op == CMD_FIND) ? rd_value : '0;
        end else if (scan_last) begin
          res_status <= ST_NOT_FOUND;
          res_slot   <= '0;
          res_value  <= '0;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          home   <= home_calc[SLOT_W-1:0];
          pos    <= home_calc[SLOT_W-1:0];
          probes <= '0;
        end
      end
      S_CHK: begin
        priority if (pos_free) begin
          res_status <= ST_DONE;
          res_slot   <= pos;
          res_value  <= '0;
        end else if (probes_out) begin
          res_status <= ST_FULL;
          res_slot   <= '0;
          res_value  <= '0;
        end else begin
          probes <= probes_inc;
        end
      end
      S_PRD: begin
      end
      S_PMOD: begin
        if (mod_done) pos <= mod_rem[SLOT_W-1:0];
      end
      S_RESULT: begin
        if (out_free) begin
          status      <= res_status;
          slot        <= res_slot;
          found_value <= res_value;
        end
      end
      default: begin
      end
    endcase
  end

  htpp_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .off_data (off_data),
    .occ      (occ)
  );

  htpp_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .steps    (mod_steps),
    .divisor  (m_act),
    .done     (mod_done),
    .rem      (mod_rem)
  );

endmodule

`default_nettype wire

/* rtl/core/htpp_checker.sv */
// ----------------------------------------------------------------------------
// htpp_checker: port-level checks for the permuted-probe hash table
// Watches result fields and busy behavior over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module htpp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [htpp_pkg::STAT_W-1:0]       status,
  input wire logic [htpp_pkg::SLOT_W-1:0]       slot,
  input wire logic signed [htpp_pkg::KEY_W-1:0] found_value
);
  import htpp_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transaction accepted");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FULL)
    else $error("status code out of range");

  a_value_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> found_value == '0)
    else $error("found_value nonzero without a hit");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> slot == '0)
    else $error("slot nonzero on refused or missing entry");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind hash_table_permuted_probe htpp_checker u_htpp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .slot        (slot),
  .found_value (found_value)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the permuted-probe hash table
// Sends offset loads, adds, finds and clears under several table sizes and
// handshake pressure mixes. A scoreboard keeps its own copy of the table,
// predicts each result and checks results in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import htpp_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int POOL_SIZE   = 96;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  value;
  } table_result_t;

  class table_scoreboard;
    logic [CFG_W-1:0] size_reg;
    bit [KEY_W-1:0]   keys [DEPTH];
    bit [KEY_W-1:0]   values [DEPTH];
    bit               occ [DEPTH];
    bit [OFF_W-1:0]   offsets [DEPTH-1];
    bit               loaded [DEPTH-1];
    int unsigned      entries;
    table_result_t    expected_q [$];
    int               mismatches;
    int               checked;
    int               status_seen [5];

    function new();
      size_reg   = SIZE_RESET;
      entries    = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int unsigned active_size();
      int unsigned m;
      m = size_reg;
      if (m == 0) m = 1;
      if (m > DEPTH) m = DEPTH;
      return m;
    endfunction

    function int unsigned home_slot(logic signed [KEY_W-1:0] k, int unsigned m);
      longint kk, r;
      kk = k;
      r = kk % longint'(m);
      if (r < 0) r += m;
      return r[31:0];
    endfunction

    function int lookup(logic [KEY_W-1:0] k, int unsigned m);
      int unsigned i;
      for (i = 0; i < m; i++) begin
        if (occ[i] && keys[i] == k) return i;
      end
      return -1;
    endfunction

    // Offset table entry that an add of k would read before it was ever loaded.
    function int missing_offset(logic signed [KEY_W-1:0] k);
      int unsigned m, home, pos, j;
      m = active_size();
      if (entries >= m || lookup(k, m) >= 0) return -1;
      home = home_slot(k, m);
      if (!occ[home]) return -1;
      for (j = 1; j < m; j++) begin
        if (!loaded[j-1]) return j - 1;
        pos = (home + offsets[j-1]) % m;
        if (!occ[pos]) return -1;
      end
      return -1;
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] idx,
                               logic [OFF_W-1:0] off, logic signed [KEY_W-1:0] k,
                               logic signed [KEY_W-1:0] v);
      table_result_t r;
      int unsigned   m, home, pos, j;
      int            hit;
      bit            ok;
      r = '0;
      m = active_size();
      case (c)
        CMD_LOAD: begin
          if (idx < DEPTH - 1) begin
            offsets[idx] = off;
            loaded[idx]  = 1'b1;
          end
        end
        CMD_ADD: begin
          hit = lookup(k, m);
          if (entries >= m) begin
            r.status = ST_FULL;
          end else if (hit >= 0) begin
            r.status = ST_DUP;
            r.slot   = SLOT_W'(hit);
          end else begin
            home = home_slot(k, m);
            pos  = home;
            ok   = !occ[home];
            for (j = 1; !ok && j < m; j++) begin
              pos = (home + offsets[j-1]) % m;
              ok  = !occ[pos];
            end
            if (ok) begin
              keys[pos]   = k;
              values[pos] = v;
              occ[pos]    = 1'b1;
              entries++;
              r.status = ST_DONE;
              r.slot   = SLOT_W'(pos);
            end else begin
              r.status = ST_FULL;
            end
          end
        end
        CMD_FIND: begin
          hit = lookup(k, m);
          if (hit >= 0) begin
            r.status = ST_FOUND;
            r.slot   = SLOT_W'(hit);
            r.value  = values[hit];
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        CMD_CLEAR: begin
          for (j = 0; j < DEPTH; j++) occ[j] = 1'b0;
          entries = 0;
        end
      endcase
      status_seen[r.status]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [SLOT_W-1:0] sl,
                               logic [KEY_W-1:0] fv);
      table_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d value %h", st, sl, fv);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || sl !== e.slot || fv !== e.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected status %0d slot %0d value %h, got %0d %0d %h",
                   checked, e.status, e.slot, e.value, st, sl, fv);
      end
    endfunction
  endclass

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd          = CMD_LOAD;
  logic [SLOT_W-1:0]       offset_index = '0;
  logic [OFF_W-1:0]        probe_offset = '0;
  logic signed [KEY_W-1:0] key          = '0;
  logic signed [KEY_W-1:0] entry_value  = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic [STAT_W-1:0]       status;
  logic [SLOT_W-1:0]       slot;
  logic signed [KEY_W-1:0] found_value;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        table_size   = SIZE_RESET;

  int unsigned             send_idle_pct  = 0;
  int unsigned             recv_stall_pct = 0;
  int                      quiet_cycles   = 0;
  int unsigned             sent           = 0;
  table_scoreboard         sb;
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  hash_table_permuted_probe u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, slot, found_value);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] idx,
                           input logic [OFF_W-1:0] off, input logic signed [KEY_W-1:0] k,
                           input logic signed [KEY_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    offset_index <= idx;
    probe_offset <= off;
    key          <= k;
    entry_value  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(c, idx, off, k, v);
    sent++;
  endtask

  task automatic write_size(input logic [CFG_W-1:0] sz);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid  <= 1'b1;
    table_size <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    sb.size_reg = sz;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] sz, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n);
    logic [OFF_W-1:0]        perm [DEPTH-1];
    logic [OFF_W-1:0]        t;
    logic signed [KEY_W-1:0] k;
    int unsigned             m, pool_n, first, j, r, pick;
    int                      need;
    write_size(sz);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    m      = sb.active_size();
    pool_n = (m + 8 < POOL_SIZE) ? m + 8 : POOL_SIZE;
    first  = sent;
    if ($urandom_range(1) == 1)
      send_item(CMD_CLEAR, SLOT_W'($urandom), OFF_W'($urandom), $urandom, $urandom);
    // load a shuffled 1..m-1 probe sequence
    if ($urandom_range(3) != 0) begin
      for (j = 0; j + 1 < m; j++) perm[j] = OFF_W'(j + 1);
      for (j = m - 1; j > 1; j--) begin
        r         = $urandom_range(j - 1);
        t         = perm[j-1];
        perm[j-1] = perm[r];
        perm[r]   = t;
      end
      for (j = 0; j + 1 < m; j++)
        send_item(CMD_LOAD, SLOT_W'(j), perm[j], $urandom, $urandom);
    end
    while (sent - first < n) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(pool_n - 1)];
      else k = $urandom;
      if (pick < 4) begin
        send_item(CMD_CLEAR, SLOT_W'($urandom), OFF_W'($urandom), k, $urandom);
      end else if (pick < 10) begin
        send_item(CMD_LOAD, SLOT_W'($urandom_range(63)), OFF_W'($urandom), k, $urandom);
      end else if (pick < 58) begin
        need = sb.missing_offset(k);
        if (need >= 0) send_item(CMD_LOAD, SLOT_W'(need), OFF_W'($urandom), k, $urandom);
        else send_item(CMD_ADD, SLOT_W'($urandom), OFF_W'($urandom), k, $urandom);
      end else begin
        send_item(CMD_FIND, SLOT_W'($urandom), OFF_W'($urandom), k, $urandom);
      end
    end
  endtask

  initial begin
    int i;
    sb = new();
    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = -1;
    key_pool[3] = 0;
    for (i = 4; i < POOL_SIZE; i++) begin
      if ($urandom_range(1) == 1) key_pool[i] = $urandom;
      else key_pool[i] = $urandom_range(400) - 200;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_LOAD, 6'd63, 6'd63, 0, 0);
    send_item(CMD_LOAD, 6'd0, 6'd1, 0, 0);
    send_item(CMD_LOAD, 6'd1, 6'd63, 0, 0);
    send_item(CMD_LOAD, 6'd62, 6'd0, 0, 0);
    send_item(CMD_ADD, 0, 0, 32'sh7fffffff, 32'sh80000000);
    send_item(CMD_ADD, 0, 0, 32'sh80000000, 32'sh7fffffff);
    send_item(CMD_ADD, 0, 0, -1, -1);
    send_item(CMD_ADD, 0, 0, 0, 32'sh5a5a5a5a);
    send_item(CMD_ADD, 0, 0, -1, 32'sh12345678);
    send_item(CMD_FIND, 0, 0, -1, 0);
    send_item(CMD_FIND, 0, 0, 5, 0);
    send_item(CMD_FIND, 0, 0, 32'sh7fffffff, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    send_item(CMD_FIND, 0, 0, -1, 0);
    write_size(7'd0);
    send_item(CMD_ADD, 0, 0, 12345, 32'shcafe0001);
    send_item(CMD_ADD, 0, 0, 7, 1);
    send_item(CMD_FIND, 0, 0, 12345, 0);
    send_item(CMD_ADD, 0, 0, 12345, 2);
    write_size(7'd4);
    send_item(CMD_LOAD, 6'd0, 6'd0, 0, 0);
    send_item(CMD_LOAD, 6'd1, 6'd0, 0, 0);
    send_item(CMD_LOAD, 6'd2, 6'd0, 0, 0);
    send_item(CMD_ADD, 0, 0, 8, 3);
    send_item(CMD_ADD, 0, 0, -3, 4);
    send_item(CMD_FIND, 0, 0, 12345, 0);
    write_size(7'd127);
    send_item(CMD_FIND, 0, 0, -3, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0);

    run_phase(7'd64, 0, 0, 250);
    run_phase(7'd5, 81, 0, 250);
    run_phase(7'd1, 0, 81, 250);
    run_phase(7'd127, 35, 35, 250);
    run_phase(7'd16, 0, 0, 250);
    run_phase(7'd0, 81, 0, 250);
    run_phase(7'd37, 0, 81, 250);
    run_phase(7'd2, 35, 35, 250);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d transactions sent across table sizes 0 to 127, %0d results checked",
             sent, sb.checked);
    $display("status mix: done %0d found %0d missing %0d duplicate %0d refused %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4]);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule
